// ===== rtl/sbmp_pkg.sv =====
// ============================================================================
// sbmp_pkg: shared types and constants of the sound board mailbox block
// Holds the item and result layouts, command codes, port addresses and the
// window map types that are used by the core, the translator and the top.
// ============================================================================
package sbmp_pkg;

    typedef enum logic [2:0] {
        CMD_HOST_WR = 3'd0,
        CMD_HOST_RD = 3'd1,
        CMD_COP_WR  = 3'd2,
        CMD_COP_RD  = 3'd3,
        CMD_XLATE   = 3'd4
    } cmd_t;

    // Host side ports
    localparam logic [7:0] HP_CONTROL = 8'h33;
    localparam logic [7:0] HP_DATA    = 8'hB3;
    localparam logic [7:0] HP_COMMAND = 8'hBB;

    // Coprocessor side ports
    localparam logic [7:0] CP_PAGE_LOW  = 8'h00;
    localparam logic [7:0] CP_COMMAND   = 8'h01;
    localparam logic [7:0] CP_DATA_IN   = 8'h02;
    localparam logic [7:0] CP_DATA_OUT  = 8'h03;
    localparam logic [7:0] CP_STATUS    = 8'h04;
    localparam logic [7:0] CP_CMD_CLR   = 8'h05;
    localparam logic [7:0] CP_VOL0      = 8'h06;
    localparam logic [7:0] CP_VOL1      = 8'h07;
    localparam logic [7:0] CP_VOL2      = 8'h08;
    localparam logic [7:0] CP_VOL3      = 8'h09;
    localparam logic [7:0] CP_STAT_DATA = 8'h0A;
    localparam logic [7:0] CP_STAT_CMD  = 8'h0B;
    localparam logic [7:0] CP_CONFIG    = 8'h0F;
    localparam logic [7:0] CP_PAGE_HIGH = 8'h10;
    localparam logic [7:0] CP_DMA_MODE  = 8'h1B;
    localparam logic [7:0] CP_DMA_ADDRH = 8'h1C;
    localparam logic [7:0] CP_DMA_ADDRM = 8'h1D;
    localparam logic [7:0] CP_DMA_ADDRL = 8'h1E;
    localparam logic [7:0] CP_DMA_CTRL  = 8'h1F;

    localparam logic [7:0] DMA_MODE_ADDR = 8'h01;
    localparam logic [7:0] NO_DATA       = 8'hFF;
    localparam logic [7:0] HOST_STAT_SET = 8'h7E;
    localparam logic [7:0] PAGE_FLOOR    = 8'h01;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  port;
        logic [7:0]  wdata;
        logic [15:0] addr;
    } item_t;

    // Lowest bits first in the stream word: rdata, is_ram, page, writable, offset
    typedef struct packed {
        logic [13:0] offset;
        logic        writable;
        logic [7:0]  page;
        logic        is_ram;
        logic [7:0]  rdata;
    } result_t;

    typedef struct packed {
        logic       ram;
        logic [7:0] page;
        logic       wr;
    } window_t;

    typedef window_t [3:0] map_t;

    localparam window_t WIN_OFF    = '{ram: 1'b0, page: 8'd0, wr: 1'b0};
    localparam window_t WIN_RAM_P3 = '{ram: 1'b1, page: 8'd3, wr: 1'b1};
    localparam window_t WIN_ROM_P1 = '{ram: 1'b0, page: 8'd1, wr: 1'b0};
    localparam map_t    MAP_RESET  = {WIN_ROM_P1, WIN_OFF, WIN_RAM_P3, WIN_OFF};

endpackage

// ===== rtl/sound_board_mailbox_and_paging_unit.sv =====
// ============================================================================
// sound_board_mailbox_and_paging_unit: sound board register block
// Stream front end around the mailbox, paging and DMA register file.
// ============================================================================
//
// Usage
//   Each item on the slave stream is one bus access or one address translation;
//   exactly one result item leaves on the master stream for every item taken,
//   in the same order. s_axis_tuser carries the command, s_axis_tdata the port,
//   write byte and address. m_axis_tdata carries the read byte and the window
//   lookup. The RAM page mask is written via cfg_we / cfg_wdata by the user,
//   only while idle; the block does not enforce this.
// Flow and throughput
//   An item is registered on acceptance and executed against the register file
//   once the result register is free or being emptied, which also registers its
//   result for the master stream. While m_axis_tready stays high, one item per
//   cycle is sustained: the register file commits one item per clock and the
//   input register refills in the same cycle that it drains.
// Reset
//   rst_n clears the valid bits of both pipeline registers and returns all state,
//   including the window map and the page mask, to its reset values.
// Stall
//   While the result register is held by a low m_axis_tready the queued item
//   waits in the input register; s_axis_tready drops only when both are full.
//
module sound_board_mailbox_and_paging_unit #(
    parameter int PAGE_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // port [7:0], wdata [15:8], addr [31:16]
    input  logic [2:0]  s_axis_tuser,   // cmd [2:0]
    // Master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // rdata [7:0], is_ram [8], page [16:9],
                                        // writable [17], offset [31:18]
    // Page mask register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import sbmp_pkg::*;

    logic    in_valid_reg,  in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;

    logic    s_accept;
    logic    advance;
    result_t core_result;

    // The queued item moves on whenever the result register is free or is
    // being emptied in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    sbmp_core #(
        .PAGE_BITS (PAGE_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .exec      (advance),
        .item      (in_item_reg),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (core_result)
    );

    always_comb
    begin
        priority if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        priority if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid bits qualify them.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= {s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                            s_axis_tdata[31:16]};
        end
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

    // An item executed in one cycle is on the output in the next.
    a_exec_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("executed item did not reach the output");

    // A held result blocks execution of the queued item.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !advance)
        else $error("item executed over a held result");

    // The input side is refused only when both stages are occupied.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input refused with a free stage");

endmodule

// ===== rtl/sbmp_xlate.sv =====
// ============================================================================
// sbmp_xlate: address translator
// Picks one of the four windows from the upper address bits and returns its
// ROM/RAM flag, page and write enable with the offset inside the page.
// ============================================================================
module sbmp_xlate #(
    parameter int PAGE_BITS = 14
) (
    input  sbmp_pkg::map_t     map,
    input  logic [15:0]        addr,
    output sbmp_pkg::window_t  win,
    output logic [13:0]        offset
);
    import sbmp_pkg::*;

    localparam logic [15:0] OFF_MASK = 16'((32'd1 << PAGE_BITS) - 32'd1);

    logic [17:0] addr_ext;
    logic [1:0]  win_idx;

    always_comb
    begin
        addr_ext = {2'b00, addr};
        win_idx  = 2'(addr_ext >> PAGE_BITS);
        win      = map[win_idx];
        offset   = 14'(addr & OFF_MASK);
    end

endmodule

// ===== rtl/sbmp_core.sv =====
// ============================================================================
// sbmp_core: mailbox, paging and DMA register file
// Decodes one item against the current state, forms its result and commits
// the new state when the item is executed.
// ============================================================================
module sbmp_core #(
    parameter int PAGE_BITS = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              exec,
    input  sbmp_pkg::item_t   item,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    output sbmp_pkg::result_t result
);
    import sbmp_pkg::*;

    logic [7:0]  mask_reg,       mask_next;
    logic [7:0]  to_host_reg,    to_host_next;
    logic [7:0]  from_host_reg,  from_host_next;
    logic [7:0]  cmd_byte_reg,   cmd_byte_next;
    logic [7:0]  status_reg,     status_next;
    logic [7:0]  low_page_reg,   low_page_next;
    logic [7:0]  high_page_reg,  high_page_next;
    logic [5:0]  board_cfg_reg,  board_cfg_next;
    logic [5:0]  vol_reg [4];
    logic [5:0]  vol_next [4];
    logic [7:0]  dma_mode_reg,   dma_mode_next;
    logic [20:0] dma_addr_reg,   dma_addr_next;
    logic [7:0]  dma_ctrl_reg,   dma_ctrl_next;
    map_t        map_reg,        map_next;

    logic        do_remap;
    logic        do_block_rst;
    logic        dma_open;
    logic [7:0]  rot_val;
    logic [7:0]  rdata;
    window_t     xl_win;
    logic [13:0] xl_offset;

    // Window map for a given board configuration and page pair
    function automatic map_t remap_fn(logic [5:0] cfg, logic [7:0] lo, logic [7:0] hi);
        map_t m;
        m[1] = WIN_RAM_P3;
        if (cfg[0])
        begin
            m[0] = '{ram: 1'b1, page: 8'd0, wr: 1'b1};
            m[2] = '{ram: 1'b1, page: lo, wr: !(cfg[1] && (lo <= PAGE_FLOOR))};
            m[3] = '{ram: 1'b1, page: hi, wr: !(cfg[1] && (hi <= PAGE_FLOOR))};
        end
        else
        begin
            m[0] = WIN_OFF;
            m[2] = '{ram: 1'b0, page: {3'b000, lo[4:0]}, wr: 1'b0};
            m[3] = '{ram: 1'b0, page: {3'b000, hi[4:0]}, wr: 1'b0};
        end
        return m;
    endfunction

    sbmp_xlate #(
        .PAGE_BITS (PAGE_BITS)
    ) u_xlate (
        .map    (map_reg),
        .addr   (item.addr),
        .win    (xl_win),
        .offset (xl_offset)
    );

    always_comb
    begin
        mask_next      = cfg_we ? cfg_wdata : mask_reg;
        to_host_next   = to_host_reg;
        from_host_next = from_host_reg;
        cmd_byte_next  = cmd_byte_reg;
        status_next    = status_reg;
        low_page_next  = low_page_reg;
        high_page_next = high_page_reg;
        board_cfg_next = board_cfg_reg;
        vol_next       = vol_reg;
        dma_mode_next  = dma_mode_reg;
        dma_addr_next  = dma_addr_reg;
        dma_ctrl_next  = dma_ctrl_reg;
        do_remap       = 1'b0;
        do_block_rst   = 1'b0;
        rdata          = NO_DATA;
        dma_open       = (dma_mode_reg == DMA_MODE_ADDR);
        rot_val        = {item.wdata[6:0], item.wdata[7]} & mask_reg;
        result         = '0;

        unique case (cmd_t'(item.cmd))
            CMD_HOST_WR:
            begin
                if (item.port == HP_CONTROL)
                begin
                    do_block_rst = item.wdata[7];
                end
                else if (item.port == HP_DATA)
                begin
                    from_host_next = item.wdata;
                    status_next[7] = 1'b1;
                end
                else if (item.port == HP_COMMAND)
                begin
                    cmd_byte_next  = item.wdata;
                    status_next[0] = 1'b1;
                end
            end
            CMD_HOST_RD:
            begin
                if (item.port == HP_DATA)
                begin
                    status_next[7] = 1'b0;
                    rdata          = to_host_reg;
                end
                else if (item.port == HP_COMMAND)
                begin
                    rdata = status_reg | HOST_STAT_SET;
                end
            end
            CMD_COP_WR:
            begin
                unique case (item.port)
                    CP_PAGE_LOW:
                    begin
                        // Extended paging keeps both pages independent
                        if (board_cfg_reg[3])
                        begin
                            low_page_next = rot_val;
                        end
                        else
                        begin
                            low_page_next  = {rot_val[7:1], 1'b0};
                            high_page_next = {rot_val[7:1], 1'b1};
                        end
                        do_remap = 1'b1;
                    end
                    CP_DATA_IN:   status_next[7] = 1'b0;
                    CP_DATA_OUT:
                    begin
                        status_next[7] = 1'b1;
                        to_host_next   = item.wdata;
                    end
                    CP_CMD_CLR:   status_next[0] = 1'b0;
                    CP_VOL0:      vol_next[0] = item.wdata[5:0];
                    CP_VOL1:      vol_next[1] = item.wdata[5:0];
                    CP_VOL2:      vol_next[2] = item.wdata[5:0];
                    CP_VOL3:      vol_next[3] = item.wdata[5:0];
                    CP_STAT_DATA: status_next[7] = low_page_reg[0];
                    CP_STAT_CMD:  status_next[0] = vol_reg[0][5];
                    CP_CONFIG:
                    begin
                        board_cfg_next = item.wdata[5:0];
                        do_remap       = 1'b1;
                    end
                    CP_PAGE_HIGH:
                    begin
                        high_page_next = rot_val;
                        do_remap       = 1'b1;
                    end
                    CP_DMA_MODE:  dma_mode_next = item.wdata;
                    CP_DMA_ADDRH:
                    begin
                        if (dma_open)
                        begin
                            dma_addr_next[20:16] = item.wdata[4:0];
                        end
                    end
                    CP_DMA_ADDRM:
                    begin
                        if (dma_open)
                        begin
                            dma_addr_next[15:8] = item.wdata;
                        end
                    end
                    CP_DMA_ADDRL:
                    begin
                        if (dma_open)
                        begin
                            dma_addr_next[7:0] = item.wdata;
                        end
                    end
                    CP_DMA_CTRL:
                    begin
                        if (dma_open)
                        begin
                            dma_ctrl_next = item.wdata;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_COP_RD:
            begin
                unique case (item.port)
                    CP_COMMAND:   rdata = cmd_byte_reg;
                    CP_DATA_IN:
                    begin
                        status_next[7] = 1'b0;
                        rdata          = from_host_reg;
                    end
                    CP_DATA_OUT:
                    begin
                        status_next[7] = 1'b1;
                        to_host_next   = NO_DATA;
                    end
                    CP_STATUS:    rdata = status_reg;
                    CP_CMD_CLR:   status_next[0] = 1'b0;
                    CP_STAT_DATA: status_next[7] = low_page_reg[0];
                    CP_STAT_CMD:  status_next[0] = vol_reg[0][5];
                    CP_CONFIG:    rdata = {2'b00, board_cfg_reg};
                    CP_DMA_MODE:  rdata = dma_mode_reg;
                    CP_DMA_ADDRH: rdata = dma_open ? {3'b000, dma_addr_reg[20:16]} : NO_DATA;
                    CP_DMA_ADDRM: rdata = dma_open ? dma_addr_reg[15:8] : NO_DATA;
                    CP_DMA_ADDRL: rdata = dma_open ? dma_addr_reg[7:0] : NO_DATA;
                    CP_DMA_CTRL:  rdata = dma_open ? dma_ctrl_reg : NO_DATA;
                    default: ;
                endcase
            end
            CMD_XLATE:
            begin
                result.is_ram   = xl_win.ram;
                result.page     = xl_win.page;
                result.writable = xl_win.wr;
                result.offset   = xl_offset;
            end
            default: ;
        endcase

        if (do_block_rst)
        begin
            board_cfg_next = '0;
            high_page_next = PAGE_FLOOR;
            dma_mode_next  = '0;
            dma_addr_next  = '0;
            dma_ctrl_next  = '0;
        end

        // The map is recomputed from the values that this item leaves behind
        priority if (do_block_rst)
        begin
            map_next = MAP_RESET;
        end
        else if (do_remap)
        begin
            map_next = remap_fn(board_cfg_next, low_page_next, high_page_next);
        end
        else
        begin
            map_next = map_reg;
        end

        result.rdata = rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= 8'hFF;
            to_host_reg   <= '0;
            from_host_reg <= '0;
            cmd_byte_reg  <= '0;
            status_reg    <= '0;
            low_page_reg  <= '0;
            high_page_reg <= PAGE_FLOOR;
            board_cfg_reg <= '0;
            vol_reg       <= '{default: '0};
            dma_mode_reg  <= '0;
            dma_addr_reg  <= '0;
            dma_ctrl_reg  <= '0;
            map_reg       <= MAP_RESET;
        end
        else
        begin
            mask_reg <= mask_next;
            if (exec)
            begin
                to_host_reg   <= to_host_next;
                from_host_reg <= from_host_next;
                cmd_byte_reg  <= cmd_byte_next;
                status_reg    <= status_next;
                low_page_reg  <= low_page_next;
                high_page_reg <= high_page_next;
                board_cfg_reg <= board_cfg_next;
                vol_reg       <= vol_next;
                dma_mode_reg  <= dma_mode_next;
                dma_addr_reg  <= dma_addr_next;
                dma_ctrl_reg  <= dma_ctrl_next;
                map_reg       <= map_next;
            end
        end
    end

    // The second window is always the fixed writable RAM page three.
    a_fixed_window: assert property (@(posedge clk) disable iff (!rst_n)
        map_reg[1] == WIN_RAM_P3)
        else $error("window one left its fixed mapping");

    // Without RAM mode the upper windows never map RAM or accept writes.
    a_rom_mode: assert property (@(posedge clk) disable iff (!rst_n)
        !board_cfg_reg[0] |-> (!map_reg[2].ram && !map_reg[3].ram &&
                               !map_reg[2].wr && !map_reg[3].wr))
        else $error("ROM mode window maps RAM");

    // Write protection of the low pages follows the page register.
    a_protect: assert property (@(posedge clk) disable iff (!rst_n)
        (board_cfg_reg[0] && board_cfg_reg[1] && (low_page_reg <= PAGE_FLOOR))
            |-> !map_reg[2].wr)
        else $error("protected page left writable");

endmodule

// ===== tb/tb_sound_board_mailbox_and_paging_unit.sv =====
// ============================================================================
// tb_sound_board_mailbox_and_paging_unit: stream-level test of the register block
// Drives host and coprocessor accesses and address translations through the
// slave stream, runs an independent copy of the mailbox, paging and DMA state
// to predict every result item, and compares each field of each result.
// ============================================================================
//
// How the bench is put together
//   An initial block builds the stimulus and pushes items into a pending
//   queue. A driver, clocked on the falling edge, takes them from the queue
//   and presents them on the slave stream with a random gap after each one.
//   A receiver, also on the falling edge, works m_axis_tready with a random
//   stall after each result, and on request holds off for a long stretch.
//   All handshakes are sampled on the rising edge in one block: an accepted
//   item is run through the predictor at once, so the expected results are
//   queued in acceptance order, and an accepted result is checked against
//   the oldest expectation.
//
// Stimulus
//   A short directed run covers the reset window map, both mailboxes and
//   their status bits, the write guard on low pages, the DMA registers with
//   the mode both off and on, the control port reset, an unknown command and
//   an unknown port. The random part is made mostly of short, well-formed
//   sequences (mailbox exchanges, page and config set-up followed by
//   translations in every window, DMA set-up and read-back, volume and
//   status updates, control writes), with plain noise mixed in.
//   The page mask is rewritten between phases, only once the block has
//   drained, and each phase uses its own idling pattern.
//
module tb_sound_board_mailbox_and_paging_unit;

    import sbmp_pkg::*;

    localparam int XLAT_BITS = 14;

    // Codes that the package does not name but the stimulus needs.
    localparam logic [2:0] CMD_UNUSED  = 3'd7;
    localparam logic [7:0] CP_UNMAPPED = 8'h20;
    localparam logic [7:0] CTL_RESET   = 8'h80;
    localparam logic [7:0] CTL_NMI     = 8'h40;

    localparam int LONG_HOLD     = 300;
    localparam int PHASE_ITEMS   = 350;
    localparam int TIMEOUT_TICKS = 800000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // port [7:0], wdata [15:8], addr [31:16]
    logic [2:0]  s_axis_tuser = '0;    // cmd [2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // rdata [7:0], is_ram [8], page [16:9],
                                       // writable [17], offset [31:18]
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = '0;

    // Items waiting to be offered, and results still owed by the block.
    item_t   pending_items [$];
    result_t expected_results [$];
    item_t   tx_item;

    int items_pushed = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int xlate_count = 0;
    int unknown_cmd_count = 0;
    int mask_settings = 0;
    int fail_count = 0;

    // Handshake flags from the last rising edge, read by the falling-edge sides.
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;

    // Idling controls.
    int tx_max_gap = 0;
    int rx_max_gap = 0;
    int tx_wait = 0;
    int rx_wait = 0;
    int rx_draw;
    int rx_hold = 0;
    int hold_req = 0;
    int hold_ack = 0;

    // Shadow of the block's state, kept by the predictor.
    logic [7:0]  page_mask;
    logic [7:0]  mb_to_host;
    logic [7:0]  mb_from_host;
    logic [7:0]  mb_command;
    logic [7:0]  mb_status;
    logic [7:0]  pg_low;
    logic [7:0]  pg_high;
    logic [5:0]  brd_cfg;
    logic [5:0]  vol [4];
    logic [7:0]  dma_mode_q;
    logic [20:0] dma_addr;
    logic [7:0]  dma_ctrl;
    window_t     win_map [4];

    sound_board_mailbox_and_paging_unit #(
        .PAGE_BITS (XLAT_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // The window map follows the config byte: in RAM mode every window is
    // RAM, and with bit 1 set the two paged windows refuse writes while they
    // sit on page 0 or 1. In ROM mode the paged windows show ROM banks.
    function automatic void remap_windows();
        win_map[0] = brd_cfg[0] ? '{ram: 1'b1, page: 8'd0, wr: 1'b1} : WIN_OFF;
        win_map[1] = WIN_RAM_P3;
        if (brd_cfg[0])
        begin
            win_map[2] = '{ram: 1'b1, page: pg_low, wr: 1'b1};
            win_map[3] = '{ram: 1'b1, page: pg_high, wr: 1'b1};
            if (brd_cfg[1] && pg_low <= PAGE_FLOOR)
                win_map[2].wr = 1'b0;
            if (brd_cfg[1] && pg_high <= PAGE_FLOOR)
                win_map[3].wr = 1'b0;
        end
        else
        begin
            win_map[2] = '{ram: 1'b0, page: pg_low & 8'h1F, wr: 1'b0};
            win_map[3] = '{ram: 1'b0, page: pg_high & 8'h1F, wr: 1'b0};
        end
    endfunction

    // What the control port reset touches; mailboxes and volumes survive it.
    function automatic void reset_board();
        brd_cfg = '0;
        pg_high = 8'd1;
        dma_mode_q = '0;
        dma_addr = '0;
        dma_ctrl = '0;
        win_map[0] = WIN_OFF;
        win_map[1] = WIN_RAM_P3;
        win_map[2] = WIN_OFF;
        win_map[3] = WIN_ROM_P1;
    endfunction

    function automatic void reset_shadow();
        page_mask = 8'hFF;
        mb_to_host = '0;
        mb_from_host = '0;
        mb_command = '0;
        mb_status = '0;
        pg_low = '0;
        for (int i = 0; i < 4; i++)
            vol[i] = '0;
        reset_board();
    endfunction

    // Runs one access against the shadow state and returns its result.
    function automatic result_t model_access(logic [2:0] cmd, logic [7:0] port,
                                             logic [7:0] wdata, logic [15:0] addr);
        result_t    r;
        logic [7:0] rot;
        logic       dma_on;
        int         w;
        logic [31:0] off;

        r = '0;
        r.rdata = NO_DATA;
        rot = {wdata[6:0], wdata[7]} & page_mask;
        dma_on = (dma_mode_q == DMA_MODE_ADDR);
        case (cmd)
            CMD_HOST_WR:
            begin
                if (port == HP_CONTROL)
                begin
                    if (wdata[7])
                        reset_board();
                end
                else if (port == HP_DATA)
                begin
                    mb_from_host = wdata;
                    mb_status[7] = 1'b1;
                end
                else if (port == HP_COMMAND)
                begin
                    mb_command = wdata;
                    mb_status[0] = 1'b1;
                end
            end
            CMD_HOST_RD:
            begin
                if (port == HP_DATA)
                begin
                    mb_status[7] = 1'b0;
                    r.rdata = mb_to_host;
                end
                else if (port == HP_COMMAND)
                    r.rdata = mb_status | HOST_STAT_SET;
            end
            CMD_COP_WR:
            begin
                case (port)
                    CP_PAGE_LOW:
                    begin
                        // Without the extended bit the pair moves together:
                        // low takes the even page, high the odd one above it.
                        pg_low = brd_cfg[3] ? rot : (rot & 8'hFE);
                        if (!brd_cfg[3])
                            pg_high = rot | 8'h01;
                        remap_windows();
                    end
                    CP_DATA_IN:   mb_status[7] = 1'b0;
                    CP_DATA_OUT:
                    begin
                        mb_status[7] = 1'b1;
                        mb_to_host = wdata;
                    end
                    CP_CMD_CLR:   mb_status[0] = 1'b0;
                    CP_VOL0, CP_VOL1, CP_VOL2, CP_VOL3:
                        vol[port[1:0] - 2'd2] = wdata[5:0];
                    CP_STAT_DATA: mb_status[7] = pg_low[0];
                    CP_STAT_CMD:  mb_status[0] = vol[0][5];
                    CP_CONFIG:
                    begin
                        brd_cfg = wdata[5:0];
                        remap_windows();
                    end
                    CP_PAGE_HIGH:
                    begin
                        pg_high = rot;
                        remap_windows();
                    end
                    CP_DMA_MODE:  dma_mode_q = wdata;
                    CP_DMA_ADDRH: if (dma_on) dma_addr[20:16] = wdata[4:0];
                    CP_DMA_ADDRM: if (dma_on) dma_addr[15:8] = wdata;
                    CP_DMA_ADDRL: if (dma_on) dma_addr[7:0] = wdata;
                    CP_DMA_CTRL:  if (dma_on) dma_ctrl = wdata;
                    default: ;
                endcase
            end
            CMD_COP_RD:
            begin
                case (port)
                    CP_COMMAND:   r.rdata = mb_command;
                    CP_DATA_IN:
                    begin
                        mb_status[7] = 1'b0;
                        r.rdata = mb_from_host;
                    end
                    CP_DATA_OUT:
                    begin
                        mb_status[7] = 1'b1;
                        mb_to_host = NO_DATA;
                    end
                    CP_STATUS:    r.rdata = mb_status;
                    CP_CMD_CLR:   mb_status[0] = 1'b0;
                    CP_STAT_DATA: mb_status[7] = pg_low[0];
                    CP_STAT_CMD:  mb_status[0] = vol[0][5];
                    CP_CONFIG:    r.rdata = {2'b00, brd_cfg};
                    CP_DMA_MODE:  r.rdata = dma_mode_q;
                    CP_DMA_ADDRH: if (dma_on) r.rdata = {3'b000, dma_addr[20:16]};
                    CP_DMA_ADDRM: if (dma_on) r.rdata = dma_addr[15:8];
                    CP_DMA_ADDRL: if (dma_on) r.rdata = dma_addr[7:0];
                    CP_DMA_CTRL:  if (dma_on) r.rdata = dma_ctrl;
                    default: ;
                endcase
            end
            CMD_XLATE:
            begin
                w = int'((32'(addr) >> XLAT_BITS) & 32'd3);
                off = 32'(addr) & ((32'd1 << XLAT_BITS) - 32'd1);
                r.is_ram = win_map[w].ram;
                r.page = win_map[w].page;
                r.writable = win_map[w].wr;
                r.offset = off[13:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_result(input result_t got);
        result_t want;

        if (expected_results.size() == 0)
        begin
            $error("result %h arrived with no access outstanding", got);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        if (got.rdata !== want.rdata)
        begin
            $error("rdata: expected %02h, got %02h", want.rdata, got.rdata);
            fail_count++;
        end
        if (got.is_ram !== want.is_ram)
        begin
            $error("is_ram: expected %0d, got %0d", want.is_ram, got.is_ram);
            fail_count++;
        end
        if (got.page !== want.page)
        begin
            $error("page: expected %02h, got %02h", want.page, got.page);
            fail_count++;
        end
        if (got.writable !== want.writable)
        begin
            $error("writable: expected %0d, got %0d", want.writable, got.writable);
            fail_count++;
        end
        if (got.offset !== want.offset)
        begin
            $error("offset: expected %04h, got %04h", want.offset, got.offset);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Handshake sampling, prediction and checking, all on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_taken <= s_axis_tvalid && s_axis_tready;
        out_taken <= m_axis_tvalid && m_axis_tready;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(result_t'(m_axis_tdata));
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(model_access(s_axis_tuser, s_axis_tdata[7:0],
                                                        s_axis_tdata[15:8],
                                                        s_axis_tdata[31:16]));
                items_accepted++;
                if (s_axis_tuser == CMD_XLATE)
                    xlate_count++;
                else if (s_axis_tuser > CMD_XLATE)
                    unknown_cmd_count++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: offers the pending items, with a random gap after each one
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (tx_wait > 0)
            begin
                s_axis_tvalid <= 1'b0;
                tx_wait <= tx_wait - 1;
            end
            else if (pending_items.size() != 0)
            begin
                tx_item = pending_items.pop_front();
                s_axis_tuser <= tx_item.cmd;
                s_axis_tdata <= {tx_item.addr, tx_item.wdata, tx_item.port};
                s_axis_tvalid <= 1'b1;
                tx_wait <= $urandom_range(0, tx_max_gap);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: a random stall after each result, and a long hold on request
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            rx_hold <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= (rx_hold == 1);
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            m_axis_tready <= (rx_wait == 1);
        end
        else if (out_taken)
        begin
            rx_draw = $urandom_range(0, rx_max_gap);
            rx_wait <= rx_draw;
            m_axis_tready <= (rx_draw == 0);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    // Mostly the three host ports, sometimes anything at all.
    function automatic logic [7:0] pick_host_port();
        case ($urandom_range(0, 3))
            0: return HP_CONTROL;
            1: return HP_DATA;
            2: return HP_COMMAND;
            default: return rnd8();
        endcase
    endfunction

    // The coprocessor map with its holes, and now and then a port far outside it.
    function automatic logic [7:0] pick_cop_port();
        if ($urandom_range(0, 7) == 0)
            return rnd8();
        return 8'($urandom_range(0, 31));
    endfunction

    // Page bytes that land on page 0 or 1 often enough to hit the write guard.
    function automatic logic [7:0] pick_page_byte();
        if ($urandom_range(0, 3) == 0)
            return rnd8() & 8'h81;
        return rnd8();
    endfunction

    task automatic push_item(input logic [2:0] cmd, input logic [7:0] port,
                             input logic [7:0] wdata, input logic [15:0] addr);
        item_t it;

        it.cmd = cmd;
        it.port = port;
        it.wdata = wdata;
        it.addr = addr;
        pending_items.push_back(it);
        items_pushed++;
    endtask

    // One short sequence of related accesses, or a burst of noise.
    task automatic queue_sequence();
        case ($urandom_range(0, 9))
            0, 1:
            begin
                // Mailbox exchange between the two sides.
                push_item(CMD_HOST_WR, HP_DATA, rnd8(), rnd16());
                if ($urandom_range(0, 1))
                    push_item(CMD_HOST_WR, HP_COMMAND, rnd8(), rnd16());
                push_item(CMD_HOST_RD, HP_COMMAND, rnd8(), rnd16());
                push_item(CMD_COP_RD, CP_STATUS, rnd8(), rnd16());
                push_item(CMD_COP_RD, CP_COMMAND, rnd8(), rnd16());
                push_item(CMD_COP_RD, CP_DATA_IN, rnd8(), rnd16());
                push_item($urandom_range(0, 1) ? CMD_COP_WR : CMD_COP_RD, CP_CMD_CLR,
                          rnd8(), rnd16());
                push_item($urandom_range(0, 1) ? CMD_COP_WR : CMD_COP_RD, CP_DATA_OUT,
                          rnd8(), rnd16());
                push_item(CMD_HOST_RD, HP_COMMAND, rnd8(), rnd16());
                push_item(CMD_HOST_RD, HP_DATA, rnd8(), rnd16());
            end
            2, 3:
            begin
                // Paging set-up, then one translation in every window.
                push_item(CMD_COP_WR, CP_CONFIG, rnd8(), rnd16());
                push_item(CMD_COP_WR, CP_PAGE_LOW, pick_page_byte(), rnd16());
                if ($urandom_range(0, 1))
                    push_item(CMD_COP_WR, CP_PAGE_HIGH, pick_page_byte(), rnd16());
                for (int i = 0; i < 4; i++)
                    push_item(CMD_XLATE, rnd8(), rnd8(), {i[1:0], 14'($urandom)});
                push_item(CMD_COP_RD, CP_CONFIG, rnd8(), rnd16());
            end
            4:
            begin
                // DMA set-up and read-back, usually with the address mode on.
                push_item(CMD_COP_WR, CP_DMA_MODE,
                          ($urandom_range(0, 3) != 0) ? DMA_MODE_ADDR : rnd8(), rnd16());
                for (int i = 0; i < 4; i++)
                    push_item(CMD_COP_WR, CP_DMA_ADDRH + 8'(i), rnd8(), rnd16());
                for (int i = 0; i < 4; i++)
                    push_item(CMD_COP_RD, CP_DMA_ADDRH + 8'(i), rnd8(), rnd16());
                push_item(CMD_COP_RD, CP_DMA_MODE, rnd8(), rnd16());
            end
            5:
            begin
                // Volumes and the status bits derived from volume 0 and the low page.
                push_item(CMD_COP_WR, CP_VOL0 + 8'($urandom_range(0, 3)), rnd8(), rnd16());
                push_item(CMD_COP_WR, CP_VOL0, rnd8(), rnd16());
                push_item($urandom_range(0, 1) ? CMD_COP_WR : CMD_COP_RD, CP_STAT_DATA,
                          rnd8(), rnd16());
                push_item($urandom_range(0, 1) ? CMD_COP_WR : CMD_COP_RD, CP_STAT_CMD,
                          rnd8(), rnd16());
                push_item(CMD_COP_RD, CP_STATUS, rnd8(), rnd16());
                push_item(CMD_HOST_RD, HP_COMMAND, rnd8(), rnd16());
            end
            6:
            begin
                // Control port, then a look at what the reset left behind.
                push_item(CMD_HOST_WR, HP_CONTROL, rnd8(), rnd16());
                push_item(CMD_XLATE, rnd8(), rnd8(), rnd16());
                push_item(CMD_XLATE, rnd8(), rnd8(), rnd16());
                push_item(CMD_COP_RD, CP_CONFIG, rnd8(), rnd16());
                push_item(CMD_COP_RD, CP_DMA_MODE, rnd8(), rnd16());
            end
            default:
            begin
                repeat (4)
                    push_item(3'($urandom_range(0, 7)),
                              $urandom_range(0, 1) ? pick_cop_port() : pick_host_port(),
                              rnd8(), rnd16());
            end
        endcase
    endtask

    // Returns once every queued item has been taken and answered.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (items_accepted != items_pushed || expected_results.size() != 0);
    endtask

    // Only called with the block drained.
    task automatic write_page_mask(input logic [7:0] mask);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mask;
        @(negedge clk);
        cfg_we <= 1'b0;
        page_mask = mask;
        mask_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0] mask;
        int         target;

        reset_shadow();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the reset page mask.
        tx_max_gap = 2;
        rx_max_gap = 2;
        push_item(CMD_HOST_RD, HP_COMMAND, 8'h00, 16'h0000);
        push_item(CMD_XLATE, 8'h00, 8'h00, 16'h0000);
        push_item(CMD_XLATE, 8'hFF, 8'hFF, 16'h7FFF);
        push_item(CMD_XLATE, 8'h00, 8'h00, 16'h8000);
        push_item(CMD_XLATE, 8'hFF, 8'hFF, 16'hFFFF);
        push_item(CMD_HOST_WR, HP_DATA, 8'hA5, 16'h0000);
        push_item(CMD_HOST_WR, HP_COMMAND, 8'h5A, 16'h0000);
        push_item(CMD_COP_RD, CP_STATUS, 8'h00, 16'h0000);
        push_item(CMD_COP_RD, CP_COMMAND, 8'h00, 16'h0000);
        push_item(CMD_COP_RD, CP_DATA_IN, 8'h00, 16'h0000);
        push_item(CMD_COP_WR, CP_DATA_OUT, 8'hC3, 16'h0000);
        push_item(CMD_HOST_RD, HP_DATA, 8'h00, 16'h0000);
        push_item(CMD_COP_RD, CP_DATA_OUT, 8'h00, 16'h0000);
        push_item(CMD_COP_WR, CP_VOL0, 8'hFF, 16'h0000);
        push_item(CMD_COP_WR, CP_STAT_CMD, 8'h00, 16'h0000);
        // RAM mode, write guard and extended paging all on; low page lands on 1.
        push_item(CMD_COP_WR, CP_CONFIG, 8'h0B, 16'h0000);
        push_item(CMD_COP_WR, CP_PAGE_LOW, 8'h80, 16'h0000);
        push_item(CMD_COP_WR, CP_PAGE_HIGH, 8'h00, 16'h0000);
        push_item(CMD_XLATE, 8'h00, 8'h00, 16'h8123);
        // DMA address ports are dead until the mode is set.
        push_item(CMD_COP_WR, CP_DMA_ADDRM, 8'h12, 16'h0000);
        push_item(CMD_COP_WR, CP_DMA_MODE, DMA_MODE_ADDR, 16'h0000);
        push_item(CMD_COP_WR, CP_DMA_ADDRH, 8'hFF, 16'h0000);
        push_item(CMD_COP_RD, CP_DMA_ADDRH, 8'h00, 16'h0000);
        push_item(CMD_HOST_WR, HP_CONTROL, CTL_NMI, 16'h0000);
        push_item(CMD_HOST_WR, HP_CONTROL, CTL_RESET, 16'h0000);
        push_item(CMD_COP_RD, CP_DMA_MODE, 8'h00, 16'h0000);
        push_item(CMD_UNUSED, CP_STATUS, 8'hFF, 16'hFFFF);
        push_item(CMD_COP_RD, CP_UNMAPPED, 8'h00, 16'h0000);
        wait_drained();

        // Random phases, each with its own page mask and idling pattern.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: mask = 8'hFF;
                1: mask = 8'h00;
                2: mask = 8'($urandom_range(1, 254));
                3: mask = 8'h7F;
                default: mask = 8'hFF;
            endcase
            write_page_mask(mask);
            case (phase)
                0: begin tx_max_gap = 6; rx_max_gap = 6; end
                1: begin tx_max_gap = 0; rx_max_gap = 0; end
                2: begin tx_max_gap = 6; rx_max_gap = 0; end
                3: begin tx_max_gap = 0; rx_max_gap = 6; end
                default: begin tx_max_gap = 0; rx_max_gap = 3; end
            endcase
            target = items_pushed + PHASE_ITEMS;
            while (items_pushed < target)
                queue_sequence();
            // With the sender running flat out, a long hold backs the block up
            // until its input stalls.
            if (phase == 1 || phase == 4)
                hold_req++;
            wait_drained();
        end

        repeat (8) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end
        $display("Checked %0d results for %0d accesses: %0d translations, %0d unknown commands.",
                 results_checked, items_accepted, xlate_count, unknown_cmd_count);
        $display("Ran under %0d page mask settings, with two long receiver holds.",
                 mask_settings);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #TIMEOUT_TICKS;
        $display("Timed out with %0d results outstanding.", expected_results.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
